// ----- rtl/core/tflt_pkg.sv -----
// Shared types and constants for the TCP flow loss tracker.
// Used by the flow table memory and the top level. No dependencies.
package tflt_pkg;

    typedef enum logic [2:0] {
        ST_IPV6    = 3'd0,
        ST_NO_ACK  = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_FULL    = 3'd3,
        ST_TRACKED = 3'd4,
        ST_CLOSED  = 3'd5,
        ST_REPORT  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        REG_BYTE_THRESHOLD = 2'd0,
        REG_FRAME_LIMIT    = 2'd1,
        REG_AGE_LIMIT      = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_READ,
        FSM_EVAL,
        FSM_OUT
    } fsm_t;

    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    // One way of a bucket: the whole flow record.
    typedef struct packed {
        logic        valid;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] ports;
        logic [31:0] start_sec;
        logic [19:0] start_usec;
        logic [31:0] fence_fwd;
        logic [31:0] fence_rev;
        logic [31:0] isn_fwd;
        logic [31:0] isn_rev;
        logic [7:0]  miss_fwd;
        logic [7:0]  frames_fwd;
        logic [7:0]  miss_rev;
        logic [7:0]  frames_rev;
    } flow_rec_t;

endpackage

// ----- rtl/core/tflt_bucket_mem.sv -----
// Flow table storage: one row per bucket holding every way side by side.
// Depends on tflt_pkg for the flow record type.
module tflt_bucket_mem #(
    parameter int BUCKETS = 1024,
    parameter int WAYS    = 11,
    parameter int AW      = 10
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output tflt_pkg::flow_rec_t        rd_data [WAYS],
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  tflt_pkg::flow_rec_t        wr_data [WAYS]
);
    import tflt_pkg::*;

    flow_rec_t mem [BUCKETS][WAYS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- rtl/core/tcp_flow_loss_tracker_unit.sv -----
// Top level of the TCP flow loss tracker: control sequencer and flow update.
// Depends on tflt_pkg and tflt_bucket_mem.
//
// Usage: one parsed TCP/IPv4 header request enters on the in channel
// (in_valid/in_ready) and exactly one result request leaves on the out channel
// (out_valid/out_ready) for each. The configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) writes byte_threshold, frame_limit and
// age_limit_sec; it is always ready and indexes past the third are ignored.
//
// Each packet passes through four steps: accept, bucket row read (registered
// memory output), evaluation of all ways in parallel with the row write-back, and
// result. There is one bucket row read and at most one write per packet, and a
// new request is taken in the cycle after the result is handed over, so the unit
// does not take a new packet before it is through with the last one.
// While out_valid is held against a low out_ready the result register keeps
// its value and no new request is accepted.
//
// After reset the table is swept clear one bucket row per cycle, rows 0 to
// BUCKETS-1, before in_ready rises. Configuration writes are accepted throughout.
module tcp_flow_loss_tracker_unit #(
    parameter int BUCKETS    = 1024,
    parameter int POOL_LIMIT = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [31:0] seq_num,
    input  logic [31:0] ack_num,
    input  logic        syn_flag,
    input  logic        ack_flag,
    input  logic        fin_flag,
    input  logic        is_ipv6,
    input  logic [31:0] now_sec,
    input  logic [19:0] now_usec,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  missed_fwd,
    output logic [7:0]  total_fwd,
    output logic [7:0]  missed_rev,
    output logic [7:0]  total_rev,
    output logic [31:0] elapsed_sec,
    output logic [19:0] elapsed_usec,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import tflt_pkg::*;

    localparam int WAYS = POOL_LIMIT + 1;
    localparam int AW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    // Configuration registers.
    logic [31:0] byte_threshold_reg;
    logic [7:0]  frame_limit_reg;
    logic [15:0] age_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_threshold_reg <= 32'd262144;
            frame_limit_reg    <= 8'd200;
            age_limit_reg      <= 16'd5;
        end
        else if (cfg_valid)
        begin
            priority case (cfg_index)
                REG_BYTE_THRESHOLD: byte_threshold_reg <= cfg_data;
                REG_FRAME_LIMIT:    frame_limit_reg    <= cfg_data[7:0];
                REG_AGE_LIMIT:      age_limit_reg      <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    // Captured request, already normalized to the flow key.
    logic        rev_reg;
    logic [31:0] ksrc_reg, kdst_reg, kports_reg;
    logic [31:0] seq_reg, ack_reg, nsec_reg;
    logic [19:0] nusec_reg;
    logic        syn_reg, ackf_reg, fin_reg, v6_reg;

    fsm_t        state_reg, state_next;
    logic [AW-1:0] clr_reg;

    logic [AW-1:0] bucket;
    assign bucket = kports_reg[AW-1:0] & AW'(BUCKETS - 1);

    flow_rec_t rd_row [WAYS];
    flow_rec_t wr_row [WAYS];
    logic      mem_we;
    logic [AW-1:0] mem_waddr;

    tflt_bucket_mem #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS),
        .AW      (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (state_reg == FSM_READ),
        .rd_addr (bucket),
        .rd_data (rd_row),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (wr_row)
    );

    assign in_ready  = (state_reg == FSM_IDLE);
    assign out_valid = (state_reg == FSM_OUT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_CLEAR: if (clr_reg == AW'(BUCKETS - 1)) state_next = FSM_IDLE;
            FSM_IDLE:  if (in_valid) state_next = FSM_READ;
            FSM_READ:  state_next = FSM_EVAL;
            FSM_EVAL:  state_next = FSM_OUT;
            FSM_OUT:   if (out_ready) state_next = FSM_IDLE;
            default:   state_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == FSM_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    logic in_rev;
    assign in_rev = (src_port > dst_port) || (src_port == dst_port && src_addr > dst_addr);

    always_ff @(posedge clk)
    begin
        if (state_reg == FSM_IDLE && in_valid)
        begin
            rev_reg    <= in_rev;
            ksrc_reg   <= in_rev ? dst_addr : src_addr;
            kdst_reg   <= in_rev ? src_addr : dst_addr;
            kports_reg <= in_rev ? {dst_port, src_port} : {src_port, dst_port};
            seq_reg    <= seq_num;
            ack_reg    <= ack_num;
            nsec_reg   <= now_sec;
            nusec_reg  <= now_usec;
            syn_reg    <= syn_flag;
            ackf_reg   <= ack_flag;
            fin_reg    <= fin_flag;
            v6_reg     <= is_ipv6;
        end
    end

    // Way search and record update on the row just read.
    logic [WAYS-1:0] hit_vec, free_vec;
    logic            found, has_free;
    flow_rec_t       hit_rec, free_rec, cur, upd;
    status_t         st_next;
    logic            report, closing, write_row;
    logic [WAYS-1:0] sel_vec;
    logic [7:0]      fr, ms;
    logic [31:0]     fence, other_isn, thr_sum;
    logic [32:0]     age_sum;
    logic [31:0]     dsec;
    logic [19:0]     dusec;

    always_comb
    begin
        found    = 1'b0;
        has_free = 1'b0;
        hit_rec  = '0;
        free_rec = '0;
        hit_vec  = '0;
        free_vec = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (rd_row[w].valid && !found && rd_row[w].src_addr == ksrc_reg &&
                rd_row[w].dst_addr == kdst_reg && rd_row[w].ports == kports_reg)
            begin
                found      = 1'b1;
                hit_vec[w] = 1'b1;
                hit_rec    = rd_row[w];
            end
            if (!rd_row[w].valid && !has_free)
            begin
                has_free    = 1'b1;
                free_vec[w] = 1'b1;
            end
        end

        free_rec.valid      = 1'b1;
        free_rec.src_addr   = ksrc_reg;
        free_rec.dst_addr   = kdst_reg;
        free_rec.ports      = kports_reg;
        free_rec.start_sec  = nsec_reg;
        free_rec.start_usec = nusec_reg;
        free_rec.isn_fwd    = rev_reg ? ack_reg - 32'd1 : seq_reg;
        free_rec.fence_fwd  = free_rec.isn_fwd;
        free_rec.isn_rev    = rev_reg ? seq_reg : ack_reg - 32'd1;
        free_rec.fence_rev  = free_rec.isn_rev;

        cur     = found ? hit_rec : free_rec;
        sel_vec = found ? hit_vec : free_vec;
        upd     = cur;
        report  = 1'b0;
        closing = fin_reg;

        fr        = rev_reg ? cur.frames_rev : cur.frames_fwd;
        ms        = rev_reg ? cur.miss_rev : cur.miss_fwd;
        fence     = rev_reg ? cur.fence_rev : cur.fence_fwd;
        other_isn = rev_reg ? cur.isn_fwd : cur.isn_rev;
        fr        = (fr == 8'hFF) ? fr : fr + 8'd1;
        if (fence > seq_reg)
        begin
            ms = (ms == 8'hFF) ? ms : ms + 8'd1;
        end
        else
        begin
            fence = seq_reg;
        end
        thr_sum = other_isn + byte_threshold_reg;
        age_sum = {1'b0, cur.start_sec} + {17'd0, age_limit_reg};
        if (!fin_reg)
        begin
            if (fr > frame_limit_reg) closing = 1'b1;
            if ({1'b0, nsec_reg} > age_sum) closing = 1'b1;
            if (ack_reg > thr_sum) report = 1'b1;
            if (rev_reg)
            begin
                upd.frames_rev = fr;
                upd.miss_rev   = ms;
                upd.fence_rev  = fence;
            end
            else
            begin
                upd.frames_fwd = fr;
                upd.miss_fwd   = ms;
                upd.fence_fwd  = fence;
            end
        end
        if (report || closing) upd.valid = 1'b0;

        write_row = 1'b0;
        if (v6_reg)            st_next = ST_IPV6;
        else if (!ackf_reg)    st_next = ST_NO_ACK;
        else if (!found && !syn_reg) st_next = ST_UNKNOWN;
        else if (!found && !has_free) st_next = ST_FULL;
        else
        begin
            write_row = 1'b1;
            st_next   = report ? ST_REPORT : (closing ? ST_CLOSED : ST_TRACKED);
        end

        dsec  = nsec_reg - upd.start_sec;
        dusec = nusec_reg - upd.start_usec;
        if (nusec_reg < upd.start_usec)
        begin
            dusec = USEC_PER_SEC + nusec_reg - upd.start_usec;
            dsec  = dsec - 32'd1;
        end

        // The sweep after reset writes empty rows.
        for (int w = 0; w < WAYS; w++)
        begin
            if (state_reg == FSM_CLEAR)
            begin
                wr_row[w] = '0;
            end
            else
            begin
                wr_row[w] = sel_vec[w] ? upd : rd_row[w];
            end
        end
    end

    assign mem_we    = (state_reg == FSM_CLEAR) || (state_reg == FSM_EVAL && write_row);
    assign mem_waddr = (state_reg == FSM_CLEAR) ? clr_reg : bucket;

    always_ff @(posedge clk)
    begin
        if (state_reg == FSM_EVAL)
        begin
            status       <= st_next;
            if (write_row && report)
            begin
                missed_fwd   <= upd.miss_fwd;
                total_fwd    <= upd.frames_fwd;
                missed_rev   <= upd.miss_rev;
                total_rev    <= upd.frames_rev;
                elapsed_sec  <= dsec;
                elapsed_usec <= dusec;
            end
            else
            begin
                missed_fwd   <= '0;
                total_fwd    <= '0;
                missed_rev   <= '0;
                total_rev    <= '0;
                elapsed_sec  <= '0;
                elapsed_usec <= '0;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while result pending");
    a_out_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == FSM_EVAL))
        else $error("result without evaluation");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped under stall");
`endif
endmodule
